// ===== rtl/das_pkg.sv =====
package das_pkg;

  localparam int PERSONS           = 4;
  localparam int EVENTS_PER_PERSON = 8;
  localparam int SLOTS             = PERSONS * EVENTS_PER_PERSON;

  localparam int FUNC_W   = 2;
  localparam int PERSON_W = 2;
  localparam int SLOT_W   = 3;
  localparam int MIN_W    = 11;
  localparam int SEC_W    = 6;
  localparam int WIN_W    = 6;
  localparam int MAXUS_W  = 26;
  localparam int MINUS_W  = 20;
  localparam int MASK_W   = 4;
  localparam int SLEEP_W  = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;
  localparam int DSEC_W   = 17;

  localparam logic [FUNC_W-1:0] FUNC_LOAD      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ACK       = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DELIVERED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLEEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLEEP = 2'd2;

  localparam logic [WIN_W-1:0]   WINDOW_RESET    = 6'd5;
  localparam logic [MAXUS_W-1:0] MAX_SLEEP_RESET = 26'd60000000;
  localparam logic [MINUS_W-1:0] MIN_SLEEP_RESET = 20'd100000;
  localparam logic [SEC_W-1:0]   SEC_LAST        = 6'd59;
  localparam logic [SEC_W-1:0]   SECS_PER_MIN    = 6'd60;
  localparam logic [MINUS_W-1:0] US_PER_SEC      = 20'd1000000;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [PERSON_W-1:0] person;
    logic [SLOT_W-1:0]   slot;
    logic [MIN_W-1:0]    event_minute;
    logic                event_enable;
    logic [MIN_W-1:0]    now_minute;
    logic [SEC_W-1:0]    now_second;
  } in_item_t;

  typedef struct packed {
    logic                changed;
    logic [MASK_W-1:0]   buzzer_mask;
    logic [MASK_W-1:0]   acked_mask;
    logic [MASK_W-1:0]   delivered_mask;
    logic [SLEEP_W-1:0]  sleep_us;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  addr;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic               valid;
    logic [MIN_W-1:0]   now;
    logic [PERSONS-1:0] inwin;
    logic               found;
    logic [MIN_W-1:0]   best;
  } token_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SECS,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/das_if.sv =====
interface das_in_if import das_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface das_out_if import das_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface das_cfg_if import das_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/das_cell.sv =====
module das_cell import das_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [MIN_W-1:0]   wr_minute,
  input  logic               wr_live,
  input  logic [WIN_W-1:0]   window,
  input  logic [PERSONS-1:0] person_bit,
  input  token_t             tok_in,
  output token_t             tok_out
);

  logic [MIN_W-1:0] minute;
  logic             live;
  logic [MIN_W:0]   win_end;
  logic             in_win;
  logic             ahead;
  logic [MIN_W-1:0] lead;
  token_t           tok_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      minute <= wr_minute;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (wr_en) begin
      live <= wr_live;
    end
  end

  always_comb begin
    win_end = {1'b0, minute} + {{(MIN_W + 1 - WIN_W){1'b0}}, window};
    in_win  = live && (tok_in.now >= minute) && ({1'b0, tok_in.now} < win_end);
    ahead   = live && (minute >= tok_in.now);
    lead    = minute - tok_in.now;
    tok_next = tok_in;
    if (in_win) begin
      tok_next.inwin = tok_in.inwin | person_bit;
    end
    if (ahead && (!tok_in.found || (lead < tok_in.best))) begin
      tok_next.found = 1'b1;
      tok_next.best  = lead;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
    if (rst) begin
      tok_out.valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/dose_alarm_scheduler_core.sv =====
// dose alarm scheduler: four people, eight event slots each
// item_in carries one item: load an event slot, clock tick, acknowledge a person,
// or mark a person's dose delivered. item_out returns exactly one result per item
// with the buzzer, acked and delivered masks after the item, a changed flag and,
// for a tick, the sleep time in microseconds (zero for other items).
// cfg writes window_minutes (index 0), max_sleep_us (1) and min_sleep_us (2);
// always ready; the user must write it only while the block is idle (unchecked).
// a tick sends a query token down a row of 32 event cells, one cell per cycle,
// then passes through the second-count state and the multiply-by-1e6 state:
// a tick result is then loaded into the output register from the done state,
// and load, acknowledge and delivered items go straight to the done state.
// one item is in flight at a time; item_in is ready again in the same cycle that
// its result appears in the output register.
// the output register holds a result until the receiver takes it; while it is
// full the next result waits in the core and item_in stays low, nothing is lost.
// rst is synchronous: all event slots become not live, all flags clear, the
// registers take their reset values and the last minute is forgotten.
module dose_alarm_scheduler_core import das_pkg::*; (
  input logic     clk,
  input logic     rst,
  das_in_if.sink  item_in,
  das_out_if.source item_out,
  das_cfg_if.sink cfg
);

  state_t state, state_next;

  logic [WIN_W-1:0]   win_min;
  logic [MAXUS_W-1:0] max_us;
  logic [MINUS_W-1:0] min_us;

  logic [PERSONS-1:0] buzzer, buzzer_next;
  logic [PERSONS-1:0] acked, acked_next;
  logic [PERSONS-1:0] delivered, delivered_next;
  logic [MIN_W-1:0]   last_minute;
  logic               last_valid;

  logic               is_tick;
  logic               new_min;
  logic [SEC_W-1:0]   cur_sec;
  logic               res_changed, changed_next;
  logic               found;
  logic [DSEC_W-1:0]  best60;
  logic [SEC_W-1:0]   secs, secs_next;
  logic [SLEEP_W-1:0] us;
  logic [SLEEP_W-1:0] capped, clamped;
  logic [SEC_W-1:0]   wait_s;
  logic [DSEC_W-1:0]  dsec;

  logic               accept;
  logic               load_go;
  logic               scan_end;
  logic               out_free;
  logic               out_load;
  logic [SEC_W-1:0]   sec_in;
  logic [SLOTS-1:0]   cell_wr;
  token_t             head;
  token_t             chain [SLOTS+1];
  out_item_t          result;

  assign accept   = item_in.valid && item_in.ready;
  assign load_go  = accept && (item_in.data.func == FUNC_LOAD);
  assign scan_end = (state == ST_SCAN) && chain[SLOTS].valid;
  assign out_free = !item_out.valid || item_out.ready;
  assign sec_in   = (item_in.data.now_second > SEC_LAST) ? SEC_LAST : item_in.data.now_second;
  assign cfg.ready = 1'b1;

  always_comb begin
    head.valid = accept && (item_in.data.func == FUNC_TICK);
    head.now   = item_in.data.now_minute;
    head.inwin = '0;
    head.found = 1'b0;
    head.best  = '0;
  end

  assign chain[0] = head;

  for (genvar c = 0; c < SLOTS; c++) begin : g_cell
    localparam int P = c / EVENTS_PER_PERSON;
    localparam int S = c % EVENTS_PER_PERSON;
    localparam logic [PERSONS-1:0] PBIT = PERSONS'(1) << P;

    assign cell_wr[c] = load_go && (int'(item_in.data.person) == P)
                        && (int'(item_in.data.slot) == S);

    das_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr_en      (cell_wr[c]),
      .wr_minute  (item_in.data.event_minute),
      .wr_live    (item_in.data.event_enable),
      .window     (win_min),
      .person_bit (PBIT),
      .tok_in     (chain[c]),
      .tok_out    (chain[c+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (item_in.data.func == FUNC_TICK) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (chain[SLOTS].valid) begin
          state_next = ST_SECS;
        end
      end
      ST_SECS: state_next = ST_MUL;
      ST_MUL:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    item_in.ready = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: item_in.ready = 1'b1;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_min <= WINDOW_RESET;
      max_us  <= MAX_SLEEP_RESET;
      min_us  <= MIN_SLEEP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.addr)
        CFG_WINDOW:    win_min <= cfg.data.wdata[WIN_W-1:0];
        CFG_MAX_SLEEP: max_us  <= cfg.data.wdata[MAXUS_W-1:0];
        CFG_MIN_SLEEP: min_us  <= cfg.data.wdata[MINUS_W-1:0];
        default: ;
      endcase
    end
  end

  // flag update at the end of a scan
  always_comb begin
    buzzer_next    = buzzer;
    acked_next     = acked;
    delivered_next = delivered;
    changed_next   = 1'b0;
    if (new_min) begin
      for (int p = 0; p < PERSONS; p++) begin
        if (buzzer[p] != (chain[SLOTS].inwin[p] && !acked[p])) begin
          buzzer_next[p] = chain[SLOTS].inwin[p] && !acked[p];
          changed_next   = 1'b1;
        end
        if (!chain[SLOTS].inwin[p]) begin
          if (acked[p]) begin
            changed_next = 1'b1;
          end
          acked_next[p]     = 1'b0;
          delivered_next[p] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buzzer      <= '0;
      acked       <= '0;
      delivered   <= '0;
      last_valid  <= 1'b0;
      last_minute <= '0;
    end else if (accept) begin
      case (item_in.data.func)
        FUNC_TICK: begin
          last_valid  <= 1'b1;
          last_minute <= item_in.data.now_minute;
        end
        FUNC_ACK: begin
          if (int'(item_in.data.person) < PERSONS) begin
            acked[item_in.data.person] <= 1'b1;
          end
        end
        FUNC_DELIVERED: begin
          if (int'(item_in.data.person) < PERSONS) begin
            delivered[item_in.data.person] <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (scan_end) begin
      buzzer    <= buzzer_next;
      acked     <= acked_next;
      delivered <= delivered_next;
    end
  end

  // second count to the next wake
  always_comb begin
    wait_s = SECS_PER_MIN - cur_sec;
    dsec   = (best60 > DSEC_W'(cur_sec)) ? best60 - DSEC_W'(cur_sec) : '0;
    if (dsec == '0) begin
      dsec = DSEC_W'(1);
    end
    secs_next = (found && (dsec < DSEC_W'(wait_s))) ? dsec[SEC_W-1:0] : wait_s;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_tick     <= (item_in.data.func == FUNC_TICK);
      new_min     <= !last_valid || (item_in.data.now_minute != last_minute);
      cur_sec     <= sec_in;
      res_changed <= 1'b0;
    end
    if (scan_end) begin
      res_changed <= changed_next;
      found       <= chain[SLOTS].found;
      best60      <= DSEC_W'(chain[SLOTS].best) * DSEC_W'(SECS_PER_MIN);
    end
    if (state == ST_SECS) begin
      secs <= secs_next;
    end
    if (state == ST_MUL) begin
      us <= SLEEP_W'(secs) * SLEEP_W'(US_PER_SEC);
    end
  end

  always_comb begin
    capped  = (us > max_us) ? max_us : us;
    clamped = (capped < SLEEP_W'(min_us)) ? SLEEP_W'(min_us) : capped;
    result.changed        = res_changed;
    result.buzzer_mask    = '0;
    result.acked_mask     = '0;
    result.delivered_mask = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < PERSONS) begin
        result.buzzer_mask[i]    = buzzer[i];
        result.acked_mask[i]     = acked[i];
        result.delivered_mask[i] = delivered[i];
      end
    end
    result.sleep_us = is_tick ? clamped : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (out_load) begin
      item_out.valid <= 1'b1;
    end else if (item_out.ready) begin
      item_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      item_out.data <= result;
    end
  end

endmodule
